>>> sv/rfx_pkg.sv
// shared constants and types for the receive ring buffer with xon/xoff flow control
package rfx_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam int MARK_W = 7;
	localparam int BYTE_W = 8;
	localparam int FILL_W = 7;
	localparam int CMP_W  = (CNT_W > MARK_W) ? CNT_W : MARK_W;

	localparam logic [MARK_W-1:0] MARK_RESET = MARK_W'(58);
	localparam logic [BYTE_W-1:0] XOFF_BYTE  = 8'h13;
	localparam logic [BYTE_W-1:0] XON_BYTE   = 8'h11;
	localparam logic [BYTE_W-1:0] NO_BYTE    = 8'h00;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_RESP
	} rfx_state_t;

	typedef struct packed {
		logic start;
		logic capture;
	} rfx_cmd_t;

endpackage

>>> sv/rfx_if.sv
// request and response channel interfaces
interface rfx_req_if;
	import rfx_pkg::*;
	logic              valid;
	logic              ready;
	logic              req_type;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output req_type, output rx_byte, input ready);
	modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface rfx_rsp_if;
	import rfx_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_byte;
	logic              read_valid;
	logic              send_flow;
	logic [BYTE_W-1:0] flow_byte;
	logic              overflow;
	logic [FILL_W-1:0] fill_count;
	logic              paused;

	modport source (output valid, output read_byte, output read_valid, output send_flow,
		output flow_byte, output overflow, output fill_count, output paused, input ready);
	modport sink   (input valid, input read_byte, input read_valid, input send_flow,
		input flow_byte, input overflow, input fill_count, input paused, output ready);
endinterface

>>> sv/rx_fifo_xon_xoff_core.sv
// top level of the receive ring buffer with xon/xoff flow control
//
//  channel  direction  handshake          word
//  req      in         req.valid/ready    req_type, rx_byte
//  rsp      out        rsp.valid/ready    read_byte .. paused
//  cfg      in         cfg_we             cfg_wdata (high mark)
//
// one word at a time: accept, then the byte store's registered read is captured,
// then the response is held
// the response waits as long as rsp.ready is low and no new word is taken meanwhile
// reset clears pointers, fill count and pause and sets the high mark to 58;
// store contents are not cleared and need no clearing pass
module rx_fifo_xon_xoff_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [rfx_pkg::MARK_W-1:0] cfg_wdata,
	rfx_req_if.sink                    req,
	rfx_rsp_if.source                  rsp
);
	import rfx_pkg::*;

	rfx_cmd_t cmd;

	// controller
	rfx_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	// datapath
	rfx_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (req.req_type),
		.rx_byte    (req.rx_byte),
		.read_byte  (rsp.read_byte),
		.read_valid (rsp.read_valid),
		.send_flow  (rsp.send_flow),
		.flow_byte  (rsp.flow_byte),
		.overflow   (rsp.overflow),
		.fill_count (rsp.fill_count),
		.paused     (rsp.paused)
	);

endmodule

>>> sv/rfx_ram.sv
// generic single write port, single read port ram with registered read
module rfx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           we,
	input  logic [$clog2(DEPTH)-1:0]       waddr,
	input  logic [WIDTH-1:0]               wdata,
	input  logic                           re,
	input  logic [$clog2(DEPTH)-1:0]       raddr,
	output logic [WIDTH-1:0]               rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> sv/rfx_ctrl.sv
// controller state machine sequencing accept, store read and response
module rfx_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output rfx_pkg::rfx_cmd_t cmd
);
	import rfx_pkg::*;

	rfx_state_t state_q;
	rfx_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_READ;
			end
			ST_READ: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		in_ready    = 1'b0;
		out_valid   = 1'b0;
		cmd.start   = 1'b0;
		cmd.capture = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_READ: begin
				cmd.capture = 1'b1;
			end
			ST_RESP: begin
				out_valid = 1'b1;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

>>> sv/rfx_dp.sv
// datapath: pointers, fill count, pause flag, high mark, byte store and result register
module rfx_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rfx_pkg::rfx_cmd_t           cmd,
	input  logic                        cfg_we,
	input  logic [rfx_pkg::MARK_W-1:0]  cfg_wdata,
	input  logic                        req_type,
	input  logic [rfx_pkg::BYTE_W-1:0]  rx_byte,
	output logic [rfx_pkg::BYTE_W-1:0]  read_byte,
	output logic                        read_valid,
	output logic                        send_flow,
	output logic [rfx_pkg::BYTE_W-1:0]  flow_byte,
	output logic                        overflow,
	output logic [rfx_pkg::FILL_W-1:0]  fill_count,
	output logic                        paused
);
	import rfx_pkg::*;

	logic [IDX_W-1:0]  widx_q, ridx_q;
	logic [CNT_W-1:0]  count_q;
	logic              paused_q;
	logic [MARK_W-1:0] mark_q;

	logic [BYTE_W-1:0] ram_rdata;
	logic              push_ok, pop_ok, full, xoff, xon;
	logic [CNT_W-1:0]  count_inc, count_dec, count_nxt;
	logic              paused_nxt;
	logic [IDX_W-1:0]  widx_inc, ridx_inc;

	logic [BYTE_W-1:0] read_byte_q;
	logic              read_valid_q, send_q, overflow_q, paused_res_q;
	logic [BYTE_W-1:0] flow_q;
	logic [CNT_W-1:0]  fill_q;

	// high mark register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= MARK_RESET;
		end else if (cfg_we) begin
			mark_q <= cfg_wdata;
		end
	end

	// push and pop decisions with flow control checks
	always_comb begin
		full      = (count_q == CNT_W'(DEPTH));
		push_ok   = (req_type == REQ_PUSH) && !full;
		pop_ok    = (req_type == REQ_POP) && (count_q != '0);
		count_inc = count_q + CNT_W'(1);
		count_dec = count_q - CNT_W'(1);
		xoff      = push_ok && (CMP_W'(count_inc) >= CMP_W'(mark_q));
		xon       = pop_ok && paused_q && (CMP_W'(count_dec) < CMP_W'(mark_q));
		widx_inc  = (widx_q == IDX_W'(DEPTH - 1)) ? '0 : widx_q + IDX_W'(1);
		ridx_inc  = (ridx_q == IDX_W'(DEPTH - 1)) ? '0 : ridx_q + IDX_W'(1);
		count_nxt = push_ok ? count_inc : (pop_ok ? count_dec : count_q);
		paused_nxt = xoff ? 1'b1 : (xon ? 1'b0 : paused_q);
	end

	// buffer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			widx_q   <= '0;
			ridx_q   <= '0;
			count_q  <= '0;
			paused_q <= 1'b0;
		end else if (cmd.start) begin
			if (push_ok) widx_q <= widx_inc;
			if (pop_ok)  ridx_q <= ridx_inc;
			count_q  <= count_nxt;
			paused_q <= paused_nxt;
		end
	end

	// byte store
	rfx_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (cmd.start && push_ok),
		.waddr (widx_q),
		.wdata (rx_byte),
		.re    (cmd.start && pop_ok),
		.raddr (ridx_q),
		.rdata (ram_rdata)
	);

	// result register, flags at accept
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			read_valid_q <= pop_ok;
			send_q       <= xoff || xon;
			flow_q       <= xoff ? XOFF_BYTE : (xon ? XON_BYTE : NO_BYTE);
			overflow_q   <= (req_type == REQ_PUSH) && full;
			fill_q       <= count_nxt;
			paused_res_q <= paused_nxt;
		end
	end

	// result register, read word once the store has answered
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			read_byte_q <= read_valid_q ? ram_rdata : NO_BYTE;
		end
	end

	assign read_byte  = read_byte_q;
	assign read_valid = read_valid_q;
	assign send_flow  = send_q;
	assign flow_byte  = flow_q;
	assign overflow   = overflow_q;
	assign fill_count = FILL_W'(fill_q);
	assign paused     = paused_res_q;

endmodule
